FILE: rtl/anx_pkg.sv
// Shared types, constants and scan-step functions for the Annex B unit splitter.
package anx_pkg;

    localparam int C_MAX_STREAM_BYTES = 65536;
    localparam int C_QUEUE_DEPTH = 4;
    localparam int C_QUEUE_AW = $clog2(C_QUEUE_DEPTH);

    localparam logic [5:0] C_AVC_SPS  = 6'd7;
    localparam logic [5:0] C_AVC_PPS  = 6'd8;
    localparam logic [5:0] C_HEVC_VPS = 6'd32;
    localparam logic [5:0] C_HEVC_SPS = 6'd33;
    localparam logic [5:0] C_HEVC_PPS = 6'd34;

    localparam logic C_CODEC_AVC  = 1'b0;
    localparam logic C_CODEC_HEVC = 1'b1;

    localparam logic C_REG_CODEC  = 1'b0;
    localparam logic C_REG_ENABLE = 1'b1;

    typedef enum logic [1:0] {
        MODE_AWAIT  = 2'd0,
        MODE_SCAN   = 2'd1,
        MODE_REJECT = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_SPS   = 2'd1,
        CLS_PPS   = 2'd2,
        CLS_VPS   = 2'd3
    } t_class;

    typedef struct packed {
        logic [2:0]  fill;
        logic [15:0] pos;
        logic [15:0] begin_pos;
        logic [1:0]  skip;
        t_mode       mode;
        logic [7:0]  hdr;
        logic        hdr_valid;
    } t_scan;

    // one queue entry: a unit to report, or a bare clear of the header tracking
    typedef struct packed {
        logic        clear_only;
        logic [15:0] begin_pos;
        logic [15:0] end_pos;
        logic [7:0]  hdr;
        logic        hdr_valid;
        logic        final_unit;
    } t_unit_rec;

    typedef struct packed {
        t_scan     st;
        logic      emit;
        t_unit_rec rec;
    } t_step;

    localparam t_scan C_SCAN_RESET = '{
        fill: 3'd0, pos: 16'd0, begin_pos: 16'd0, skip: 2'd0,
        mode: MODE_AWAIT, hdr: 8'd0, hdr_valid: 1'b0
    };

    // highest reportable position for a given stream size
    function automatic logic [15:0] f_pos_limit(input int max_bytes);
        if ((max_bytes - 1) > 65535) begin
            return 16'hFFFF;
        end
        return 16'(max_bytes - 1);
    endfunction

    function automatic logic [15:0] f_sat(input logic [16:0] x, input logic [15:0] lim);
        if (x > {1'b0, lim}) begin
            return lim;
        end
        return x[15:0];
    endfunction

    // k-th pending byte, oldest first
    function automatic logic [7:0] f_wbyte(input logic [31:0] win, input logic [2:0] fill,
                                           input logic [1:0] k);
        logic [2:0] idx;
        idx = fill - 3'd1 - {1'b0, k};
        if ({1'b0, k} >= fill) begin
            return 8'd0;
        end
        case (idx[1:0])
            2'd0:    return win[7:0];
            2'd1:    return win[15:8];
            2'd2:    return win[23:16];
            default: return win[31:24];
        endcase
    endfunction

    function automatic logic [2:0] f_match(input logic [31:0] win, input logic [2:0] fill);
        logic [7:0] b0, b1, b2, b3;
        b0 = f_wbyte(win, fill, 2'd0);
        b1 = f_wbyte(win, fill, 2'd1);
        b2 = f_wbyte(win, fill, 2'd2);
        b3 = f_wbyte(win, fill, 2'd3);
        if (fill >= 3'd3 && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h01) begin
            return 3'd3;
        end
        if (fill >= 3'd4 && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h00 && b3 == 8'h01) begin
            return 3'd4;
        end
        return 3'd0;
    endfunction

    // decide the oldest pending position and drop it
    function automatic t_step f_decide(input t_scan st, input logic [31:0] win,
                                       input logic [15:0] lim);
        t_step      res;
        logic [2:0] len;
        logic [15:0] p;
        res.st   = st;
        res.emit = 1'b0;
        res.rec  = '0;
        p   = st.pos;
        len = f_match(win, st.fill);
        if (st.fill != 3'd0) begin
            case (st.mode)
                MODE_AWAIT: begin
                    if (len != 3'd0) begin
                        res.st.mode      = MODE_SCAN;
                        res.st.skip      = 2'(len - 3'd1);
                        res.st.begin_pos = f_sat({1'b0, p} + {14'd0, len}, lim);
                        res.st.hdr_valid = 1'b0;
                    end else begin
                        res.st.mode = MODE_REJECT;
                    end
                end
                MODE_SCAN: begin
                    if (st.skip != 2'd0) begin
                        res.st.skip = st.skip - 2'd1;
                    end else if (len != 3'd0) begin
                        res.emit              = 1'b1;
                        res.rec.begin_pos     = st.begin_pos;
                        res.rec.end_pos       = p;
                        res.rec.hdr           = st.hdr;
                        res.rec.hdr_valid     = st.hdr_valid;
                        res.st.skip           = 2'(len - 3'd1);
                        res.st.begin_pos      = f_sat({1'b0, p} + {14'd0, len}, lim);
                        res.st.hdr_valid      = 1'b0;
                    end else if (!st.hdr_valid) begin
                        res.st.hdr       = f_wbyte(win, st.fill, 2'd0);
                        res.st.hdr_valid = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            res.st.fill = st.fill - 3'd1;
            res.st.pos  = f_sat({1'b0, p} + 17'd1, lim);
        end
        return res;
    endfunction

endpackage

FILE: rtl/annexb_nal_splitter_classifier.sv
// Top level: configuration registers and front/queue/back assembly.
// Takes an Annex B byte stream at one byte per cycle and returns one descriptor per
// NAL unit (start, length, type, class; the last one also flags whether the needed
// parameter sets were seen). A byte is taken in the cycle it is offered whenever the
// four-entry descriptor queue has two free places; the scan of each byte, and the
// flush of up to four pending positions on the end-of-stream byte, finish in that
// same cycle. Descriptors leave one per cycle while the output is ready, through a
// registered output. Input is held while three or more records wait: back-to-back
// end-of-stream bytes that each give two descriptors can hold input, and a stalled
// output holds input once the queue backs up. With nothing waiting ahead of it, a
// descriptor passes through the queue into the output register once its unit is decided.
// Positions saturate at MAX_STREAM_BYTES - 1, and never above 65535.
module annexb_nal_splitter_classifier import anx_pkg::*; #(
    parameter int MAX_STREAM_BYTES = C_MAX_STREAM_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_unit_start,
    output logic [15:0] o_unit_length,
    output logic [5:0]  o_unit_type,
    output logic [1:0]  o_unit_class,
    output logic        o_headers_complete,
    output logic        o_last
);

    logic      r_codec, r_enable;
    logic      push0, push1, pop, avail, room2;
    t_unit_rec rec0, rec1, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec  <= C_CODEC_AVC;
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                C_REG_CODEC:  r_codec  <= i_cfg_data;
                C_REG_ENABLE: r_enable <= i_cfg_data;
                default: ;
            endcase
        end
    end

    anx_front #(
        .MAX_STREAM_BYTES (MAX_STREAM_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (r_enable),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .i_room2       (room2),
        .o_push0       (push0),
        .o_push1       (push1),
        .o_rec0        (rec0),
        .o_rec1        (rec1)
    );

    anx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_rec0  (rec0),
        .i_rec1  (rec1),
        .i_pop   (pop),
        .o_head  (head),
        .o_avail (avail),
        .o_room2 (room2)
    );

    anx_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_codec            (r_codec),
        .i_head             (head),
        .i_avail            (avail),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_unit_start       (o_unit_start),
        .o_unit_length      (o_unit_length),
        .o_unit_type        (o_unit_type),
        .o_unit_class       (o_unit_class),
        .o_headers_complete (o_headers_complete),
        .o_last             (o_last)
    );

endmodule

FILE: rtl/anx_front.sv
// Front end: byte window, start-code scan and unit boundary records.
module anx_front import anx_pkg::*; #(
    parameter int MAX_STREAM_BYTES = C_MAX_STREAM_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_enable,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_data,
    input  logic        i_room2,
    output logic        o_push0,
    output logic        o_push1,
    output t_unit_rec   o_rec0,
    output t_unit_rec   o_rec1
);

    localparam logic [15:0] POS_LIMIT = f_pos_limit(MAX_STREAM_BYTES);

    t_scan       r_scan, n_scan;
    logic [31:0] r_window, n_window;
    logic        accept;
    t_scan       st;
    t_step       stp;
    logic [31:0] win;
    t_unit_rec   fin;

    assign o_in_ready = i_room2;
    assign accept     = i_in_valid && i_room2;

    always_comb begin
        n_scan   = r_scan;
        n_window = r_window;
        o_push0  = 1'b0;
        o_push1  = 1'b0;
        o_rec0   = '0;
        o_rec1   = '0;
        st       = r_scan;
        stp      = '0;
        fin      = '0;
        win      = {r_window[23:0], i_data_byte};
        if (accept) begin
            if (i_enable) begin
                if (st.fill < 3'd4) begin
                    st.fill = st.fill + 3'd1;
                end
                for (int i = 0; i < 4; i++) begin
                    if ((i == 0 && st.fill == 3'd4) || i_end_of_data) begin
                        stp = f_decide(st, win, POS_LIMIT);
                        st  = stp.st;
                        if (stp.emit) begin
                            if (!o_push0) begin
                                o_push0 = 1'b1;
                                o_rec0  = stp.rec;
                            end else begin
                                o_push1 = 1'b1;
                                o_rec1  = stp.rec;
                            end
                        end
                    end
                end
                if (i_end_of_data) begin
                    if (st.mode == MODE_SCAN) begin
                        fin.begin_pos  = st.begin_pos;
                        fin.end_pos    = st.pos;
                        fin.hdr        = st.hdr;
                        fin.hdr_valid  = st.hdr_valid;
                        fin.final_unit = 1'b1;
                        if (!o_push0) begin
                            o_push0 = 1'b1;
                            o_rec0  = fin;
                        end else begin
                            o_push1 = 1'b1;
                            o_rec1  = fin;
                        end
                    end
                    n_scan   = C_SCAN_RESET;
                    n_window = 32'd0;
                end else begin
                    n_scan   = st;
                    n_window = win;
                end
            end else if (i_end_of_data) begin
                n_scan            = C_SCAN_RESET;
                n_window          = 32'd0;
                o_push0           = 1'b1;
                o_rec0.clear_only = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan   <= C_SCAN_RESET;
            r_window <= 32'd0;
        end else begin
            r_scan   <= n_scan;
            r_window <= n_window;
        end
    end

endmodule

FILE: rtl/anx_queue.sv
// Record queue between front and back: two writes and one read per cycle.
module anx_queue import anx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push0,
    input  logic      i_push1,
    input  t_unit_rec i_rec0,
    input  t_unit_rec i_rec1,
    input  logic      i_pop,
    output t_unit_rec o_head,
    output logic      o_avail,
    output logic      o_room2
);

    t_unit_rec               r_mem [C_QUEUE_DEPTH];
    logic [C_QUEUE_AW-1:0]   r_wptr, n_wptr;
    logic [C_QUEUE_AW-1:0]   r_rptr, n_rptr;
    logic [C_QUEUE_AW:0]     r_count, n_count;
    logic                    pop;
    logic [C_QUEUE_AW-1:0]   wptr1;

    assign o_avail = (r_count != '0);
    assign o_room2 = (r_count <= (C_QUEUE_AW+1)'(C_QUEUE_DEPTH - 2));
    assign o_head  = r_mem[r_rptr];
    assign pop     = i_pop && o_avail;
    assign wptr1   = r_wptr + 1'b1;

    always_comb begin
        n_wptr  = r_wptr + C_QUEUE_AW'(i_push0) + C_QUEUE_AW'(i_push1);
        n_rptr  = r_rptr + C_QUEUE_AW'(pop);
        n_count = r_count + (C_QUEUE_AW+1)'(i_push0) + (C_QUEUE_AW+1)'(i_push1)
                - (C_QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wptr] <= i_rec0;
        end
        if (i_push1) begin
            r_mem[wptr1] <= i_rec1;
        end
    end

endmodule

FILE: rtl/anx_back.sv
// Back end: unit type and class, header tracking and descriptor output register.
module anx_back import anx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_codec,
    input  t_unit_rec   i_head,
    input  logic        i_avail,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_unit_start,
    output logic [15:0] o_unit_length,
    output logic [5:0]  o_unit_type,
    output logic [1:0]  o_unit_class,
    output logic        o_headers_complete,
    output logic        o_last
);

    logic        r_valid, n_valid;
    logic [2:0]  r_seen, n_seen;
    logic [15:0] r_start, r_length;
    logic [5:0]  r_type;
    t_class      r_class;
    logic        r_complete, r_last;
    logic [5:0]  typ;
    t_class      cls;
    logic [2:0]  seen_upd;
    logic        complete;
    logic [15:0] length;
    logic        load;

    assign o_pop = i_avail && (!r_valid || i_out_ready);
    assign load  = o_pop && !i_head.clear_only;

    always_comb begin
        typ = 6'd0;
        cls = CLS_OTHER;
        if (i_head.hdr_valid) begin
            if (i_codec == C_CODEC_AVC) begin
                typ = {1'b0, i_head.hdr[4:0]};
                if (typ == C_AVC_SPS) begin
                    cls = CLS_SPS;
                end else if (typ == C_AVC_PPS) begin
                    cls = CLS_PPS;
                end
            end else begin
                typ = i_head.hdr[6:1];
                if (typ == C_HEVC_SPS) begin
                    cls = CLS_SPS;
                end else if (typ == C_HEVC_PPS) begin
                    cls = CLS_PPS;
                end else if (typ == C_HEVC_VPS) begin
                    cls = CLS_VPS;
                end
            end
        end
        seen_upd = r_seen;
        case (cls)
            CLS_SPS: seen_upd[0] = 1'b1;
            CLS_PPS: seen_upd[1] = 1'b1;
            CLS_VPS: seen_upd[2] = 1'b1;
            default: ;
        endcase
        complete = 1'b0;
        if (i_head.final_unit) begin
            if (i_codec == C_CODEC_AVC) begin
                complete = (seen_upd[1:0] == 2'b11);
            end else begin
                complete = (seen_upd == 3'b111);
            end
        end
        length = (i_head.end_pos >= i_head.begin_pos) ? i_head.end_pos - i_head.begin_pos
                                                      : 16'd0;
    end

    always_comb begin
        n_valid = r_valid && !i_out_ready;
        n_seen  = r_seen;
        if (o_pop) begin
            if (i_head.clear_only || i_head.final_unit) begin
                n_seen = 3'd0;
            end else begin
                n_seen = seen_upd;
            end
        end
        if (load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seen  <= 3'd0;
        end else begin
            r_valid <= n_valid;
            r_seen  <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_start    <= i_head.begin_pos;
            r_length   <= length;
            r_type     <= typ;
            r_class    <= cls;
            r_complete <= complete;
            r_last     <= i_head.final_unit;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_unit_start       = r_start;
    assign o_unit_length      = r_length;
    assign o_unit_type        = r_type;
    assign o_unit_class       = r_class;
    assign o_headers_complete = r_complete;
    assign o_last             = r_last;

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for the Annex B unit splitter: streams, register changes, descriptor checks.
module tb;
    import anx_pkg::*;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] len;
        logic [5:0]  nal_type;
        t_class      cls;
        logic        complete;
        logic        fin;
    } t_nal_desc;

    class t_nal_scoreboard;
        logic        codec;
        logic        enable;
        logic [31:0] win;
        int unsigned fill;
        int unsigned pos;
        int unsigned unit_pos;
        int unsigned skip;
        t_mode       mode;
        logic [7:0]  hdr;
        bit          hdr_ok;
        logic [2:0]  seen;
        t_nal_desc   expq[$];
        int unsigned errors;
        int unsigned bytes_taken;
        int unsigned units_seen;
        int unsigned ends_seen;
        int unsigned complete_seen;

        function new();
            codec = C_CODEC_AVC;
            enable = 1'b1;
            errors = 0;
            bytes_taken = 0;
            units_seen = 0;
            ends_seen = 0;
            complete_seen = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            win = '0;
            fill = 0;
            pos = 0;
            unit_pos = 0;
            skip = 0;
            mode = MODE_AWAIT;
            hdr = '0;
            hdr_ok = 1'b0;
            seen = '0;
        endfunction

        function int unsigned sat16(int unsigned x);
            return (x > 65535) ? 65535 : x;
        endfunction

        // oldest undecided byte is k = 0
        function logic [7:0] pending(int unsigned k);
            if (k >= fill) return 8'h00;
            return win[8 * (fill - 1 - k) +: 8];
        endfunction

        function int unsigned code_len(int unsigned avail);
            if (avail >= 3 && pending(0) == 8'h00 && pending(1) == 8'h00 && pending(2) == 8'h01)
                return 3;
            if (avail >= 4 && pending(0) == 8'h00 && pending(1) == 8'h00 && pending(2) == 8'h00
                && pending(3) == 8'h01)
                return 4;
            return 0;
        endfunction

        function void report_unit(int unsigned stop, bit fin);
            t_nal_desc d;
            d = '0;
            if (hdr_ok) begin
                if (codec == C_CODEC_AVC) begin
                    d.nal_type = {1'b0, hdr[4:0]};
                    if (d.nal_type == C_AVC_SPS) d.cls = CLS_SPS;
                    else if (d.nal_type == C_AVC_PPS) d.cls = CLS_PPS;
                end else begin
                    d.nal_type = hdr[6:1];
                    if (d.nal_type == C_HEVC_SPS) d.cls = CLS_SPS;
                    else if (d.nal_type == C_HEVC_PPS) d.cls = CLS_PPS;
                    else if (d.nal_type == C_HEVC_VPS) d.cls = CLS_VPS;
                end
            end
            if (d.cls != CLS_OTHER) seen[int'(d.cls) - 1] = 1'b1;
            if (fin)
                d.complete = (codec == C_CODEC_AVC) ? (seen[1:0] == 2'b11) : (seen == 3'b111);
            d.start = unit_pos[15:0];
            d.len = (stop >= unit_pos) ? 16'(stop - unit_pos) : 16'd0;
            d.fin = fin;
            expq.push_back(d);
        endfunction

        function void decide(int unsigned avail);
            int unsigned p;
            int unsigned n;
            p = pos;
            if (fill == 0) return;
            n = code_len(avail);
            if (mode == MODE_AWAIT) begin
                if (n != 0) begin
                    mode = MODE_SCAN;
                    skip = n - 1;
                    unit_pos = sat16(p + n);
                    hdr_ok = 1'b0;
                end else begin
                    mode = MODE_REJECT;
                end
            end else if (mode == MODE_SCAN) begin
                if (skip > 0) begin
                    skip--;
                end else if (n != 0) begin
                    report_unit(p, 1'b0);
                    skip = n - 1;
                    unit_pos = sat16(p + n);
                    hdr_ok = 1'b0;
                end else if (!hdr_ok) begin
                    hdr = pending(0);
                    hdr_ok = 1'b1;
                end
            end
            fill--;
            pos = sat16(p + 1);
        endfunction

        function void note_byte(logic [7:0] b, logic eod);
            if (!enable) begin
                if (eod) clear_stream();
                return;
            end
            bytes_taken++;
            win = {win[23:0], b};
            if (fill < 4) fill++;
            if (fill == 4) decide(4);
            if (eod) begin
                while (fill > 0) decide(fill);
                if (mode == MODE_SCAN) report_unit(pos, 1'b1);
                clear_stream();
            end
        endfunction

        function void field_cmp(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_unit(logic [15:0] start, logic [15:0] len, logic [5:0] nt,
                                 logic [1:0] cls, logic complete, logic fin);
            t_nal_desc want;
            if (expq.size() == 0) begin
                errors++;
                $display("%0t: descriptor with none expected: start %0d length %0d type %0d",
                         $time, start, len, nt);
                return;
            end
            want = expq.pop_front();
            units_seen++;
            if (fin === 1'b1) ends_seen++;
            if (fin === 1'b1 && complete === 1'b1) complete_seen++;
            field_cmp("unit_start", want.start, start);
            field_cmp("unit_length", want.len, len);
            field_cmp("unit_type", want.nal_type, nt);
            field_cmp("unit_class", want.cls, cls);
            field_cmp("headers_complete", want.complete, complete);
            field_cmp("last", want.fin, fin);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_data = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [15:0] unit_start;
    logic [15:0] unit_length;
    logic [5:0]  unit_type;
    logic [1:0]  unit_class;
    logic        headers_complete;
    logic        unit_last;

    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned items_fed = 0;
    logic [8:0]  feed_q[$];
    t_nal_scoreboard sb = new();

    annexb_nal_splitter_classifier u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_data_byte        (data_byte),
        .i_end_of_data      (end_of_data),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_unit_start       (unit_start),
        .o_unit_length      (unit_length),
        .o_unit_type        (unit_type),
        .o_unit_class       (unit_class),
        .o_headers_complete (headers_complete),
        .o_last             (unit_last)
    );

    always #10 clk = ~clk;

    // byte transfers are noted before descriptors are checked
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_byte(data_byte, end_of_data);
            if (out_valid && out_ready)
                sb.check_unit(unit_start, unit_length, unit_type, unit_class,
                              headers_complete, unit_last);
        end
    end

    always @(negedge clk) begin
        if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 17);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_byte(logic [7:0] b, logic eod);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_data <= eod;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_fed++;
    endtask

    task automatic write_reg(logic idx, logic val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expq.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == C_REG_CODEC) sb.codec = val;
        else sb.enable = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void push_bytes(logic [7:0] s[$], bit fin);
        foreach (s[i]) feed_q.push_back({1'b0, s[i]});
        if (fin) feed_q[feed_q.size() - 1][8] = 1'b1;
    endfunction

    function automatic void push_code();
        if ($urandom_range(0, 1)) feed_q.push_back(9'h000);
        feed_q.push_back(9'h000);
        feed_q.push_back(9'h000);
        feed_q.push_back(9'h001);
    endfunction

    // mostly well-formed streams; some pure noise, some with junk ahead of the first code
    function automatic void build_stream();
        int unsigned units;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) feed_q.push_back({1'b0, 8'($urandom)});
        end else begin
            if (kind == 1) feed_q.push_back({1'b0, 8'($urandom_range(1, 255))});
            push_code();
            units = $urandom_range(1, 6);
            for (int u = 0; u < units; u++) begin
                if ($urandom_range(0, 7) != 0) begin
                    case ($urandom_range(0, 6))
                        0: feed_q.push_back({1'b0, 8'h60 | 8'(C_AVC_SPS)});
                        1: feed_q.push_back({1'b0, 8'h60 | 8'(C_AVC_PPS)});
                        2: feed_q.push_back({2'b00, C_HEVC_VPS, 1'b0});
                        3: feed_q.push_back({2'b00, C_HEVC_SPS, 1'b0});
                        4: feed_q.push_back({2'b00, C_HEVC_PPS, 1'b0});
                        default: feed_q.push_back({1'b0, 8'($urandom)});
                    endcase
                    repeat ($urandom_range(0, 10)) begin
                        case ($urandom_range(0, 3))
                            0: feed_q.push_back(9'h000);
                            1: feed_q.push_back(9'h001);
                            default: feed_q.push_back({1'b0, 8'($urandom)});
                        endcase
                    end
                end
                if (u + 1 < units || $urandom_range(0, 4) == 0) push_code();
            end
        end
        feed_q[feed_q.size() - 1][8] = 1'b1;
    endfunction

    task automatic feed_items(int unsigned n);
        logic [8:0] e;
        repeat (n) begin
            if (feed_q.size() == 0) build_stream();
            e = feed_q.pop_front();
            send_byte(e[7:0], e[8]);
        end
    endtask

    initial begin
        logic [7:0]  s[$];
        int unsigned n;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // long and short codes, SPS, PPS, back-to-back codes, trailing code
        s = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h60 | 8'(C_AVC_SPS), 8'hFF, 8'h00, 8'h00,
              8'h01, 8'h60 | 8'(C_AVC_PPS), 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
        push_bytes(s, 1'b1);
        // no leading start code
        s = '{8'h12, 8'h00, 8'h00, 8'h01};
        push_bytes(s, 1'b1);
        feed_items(feed_q.size());

        write_reg(C_REG_CODEC, C_CODEC_HEVC);
        s = '{8'h00, 8'h00, 8'h01, {1'b0, C_HEVC_VPS, 1'b0}, 8'h00, 8'h00, 8'h01,
              {1'b0, C_HEVC_SPS, 1'b0}, 8'h00, 8'h00, 8'h01, {1'b0, C_HEVC_PPS, 1'b0}};
        push_bytes(s, 1'b1);
        feed_items(feed_q.size());

        write_reg(C_REG_ENABLE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        write_reg(C_REG_ENABLE, 1'b1);

        // random phases; register changes may fall in the middle of a stream
        while (items_fed < 1550) begin
            n = $urandom_range(0, 5);
            if (n == 0) begin
                write_reg(C_REG_ENABLE, 1'b0);
                repeat ($urandom_range(3, 12))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                write_reg(C_REG_ENABLE, 1'b1);
            end else begin
                if (n == 1) write_reg(C_REG_CODEC, 1'($urandom));
                feed_items($urandom_range(20, 200));
            end
        end

        // tail without idling
        @(posedge clk);
        idle_on = 1'b0;
        feed_items(150);
        feed_items(feed_q.size());

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expq.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        $display("Run took %0d stream bytes and checked %0d descriptors, %0d at stream ends",
                 sb.bytes_taken, sb.units_seen, sb.ends_seen);
        $display("(%0d with all parameter sets), over both codecs and with parsing toggled.",
                 sb.complete_seen);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("Timed out with %0d descriptors outstanding", sb.expq.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: annexb_nal_splitter_classifier.f
rtl/anx_pkg.sv
rtl/anx_front.sv
rtl/anx_queue.sv
rtl/anx_back.sv
rtl/annexb_nal_splitter_classifier.sv
tb/sv/tb.sv
